// ===== rtl/core/pli_pkg.sv =====
// pli_pkg: shared widths, codes and struct types of the piecewise linear interpolator
// used by pli_cell, pli_arith and piecewise_linear_interpolator; no dependencies
`default_nettype none

package pli_pkg;

   localparam int X_W            = 32;
   localparam int Y_FRAC_BITS    = 16;
   localparam int Y_W            = Y_FRAC_BITS + 1;
   localparam int IDX_W          = 6;
   localparam int CFG_W          = 7;
   localparam int DEF_MAX_POINTS = 64;

   localparam logic [Y_W-1:0]   Y_ONE             = {1'b1, {Y_FRAC_BITS{1'b0}}};
   localparam logic [CFG_W-1:0] POINT_COUNT_RESET = 7'd2;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic             func;
      logic [IDX_W-1:0] entry_index;
      logic [X_W-1:0]   x_value;
      logic [Y_W-1:0]   y_value;
      logic             is_infinite;
   } req_type;

   typedef struct packed {
      logic [Y_W-1:0] y_result;
      logic           out_of_range;
   } rsp_type;

   // breakpoint write broadcast to the cells
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] slot;
      logic [X_W-1:0]   x;
      logic [Y_W-1:0]   y;
   } load_type;

   // query token handed from cell to cell
   typedef struct packed {
      logic           active;
      logic           direct;
      logic           direct_one;
      logic           found;
      logic           pend;
      logic           flag;
      logic [X_W-1:0] xq;
      logic [X_W-1:0] prev_x;
      logic [Y_W-1:0] prev_y;
      logic [X_W-1:0] x0;
      logic [Y_W-1:0] y0;
      logic [X_W-1:0] x1;
      logic [Y_W-1:0] y1;
   } token_type;

   typedef struct packed {
      logic idle;
      logic done;
   } arith_stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/pli_cell.sv =====
// pli_cell: one breakpoint slot of the search chain, holds x/y and passes the query token on
// depends on pli_pkg
`default_nettype none

module pli_cell #(
   parameter int  MAX_POINTS = 64,
   parameter int  CELL_INDEX = 0,
   localparam int CNT_W      = $clog2(MAX_POINTS + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pli_pkg::load_type  load_i,
   input  wire logic [CNT_W-1:0]   n_eff,
   input  wire pli_pkg::token_type tok_i,
   output pli_pkg::token_type      tok_o
);
   import pli_pkg::*;

   localparam logic [CNT_W-1:0] MY_IDX   = CNT_W'(CELL_INDEX);
   localparam logic [CNT_W-1:0] MY_NEXT  = CNT_W'(CELL_INDEX + 1);
   localparam bit               IS_FIRST = (CELL_INDEX == 0);
   localparam bit               SLOT_OK  = (CELL_INDEX < (2 ** IDX_W));
   localparam logic [IDX_W-1:0] MY_SLOT  = IDX_W'(CELL_INDEX);

   logic [X_W-1:0] x_ff, x_in;
   logic [Y_W-1:0] y_ff, y_in;
   token_type      tok_ff, tok_in;
   logic           active_ff;
   logic           hit;
   logic           last_cell;

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (load_i.en && SLOT_OK && (load_i.slot == MY_SLOT)) begin
         x_in = load_i.x;
         y_in = load_i.y;
      end
   end

   assign hit       = (x_ff >= tok_i.xq);
   assign last_cell = (n_eff == MY_NEXT);

   always_comb begin
      tok_in = tok_i;
      if (tok_i.active && !tok_i.direct) begin
         if (tok_i.pend) begin
            // first breakpoint already matched, this cell closes segment 0..1
            tok_in.x1   = x_ff;
            tok_in.y1   = y_ff;
            tok_in.pend = 1'b0;
         end else if (!tok_i.found && (MY_IDX < n_eff)) begin
            if (hit || last_cell) begin
               tok_in.found = 1'b1;
               if (IS_FIRST) begin
                  tok_in.x0   = x_ff;
                  tok_in.y0   = y_ff;
                  tok_in.pend = 1'b1;
                  tok_in.flag = (tok_i.xq < x_ff);
               end else begin
                  tok_in.x0   = tok_i.prev_x;
                  tok_in.y0   = tok_i.prev_y;
                  tok_in.x1   = x_ff;
                  tok_in.y1   = y_ff;
                  // past the last breakpoint in use: extrapolate the end segment
                  tok_in.flag = !hit;
               end
            end
            tok_in.prev_x = x_ff;
            tok_in.prev_y = y_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      tok_ff <= tok_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= tok_in.active;
      end
   end

   always_comb begin
      tok_o        = tok_ff;
      tok_o.active = active_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/core/pli_arith.sv =====
// pli_arith: segment arithmetic, one multiply then a bit-serial restoring divide and saturation
// depends on pli_pkg
`default_nettype none

module pli_arith (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire pli_pkg::token_type tok_i,
   input  wire logic               take,
   output pli_pkg::arith_stat_type stat_o,
   output pli_pkg::rsp_type        res_o
);
   import pli_pkg::*;

   localparam int QB     = Y_FRAC_BITS + 2;
   localparam int PROD_W = X_W + Y_W;
   localparam int RES_W  = Y_W + 3;
   localparam int CNT_DW = $clog2(QB + 1);

   localparam logic [QB-1:0]     QUO_CAP = {2'b10, {Y_FRAC_BITS{1'b0}}};
   localparam logic [CNT_DW-1:0] CNT_ONE = CNT_DW'(1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PREP  = 3'd1;
   localparam logic [2:0] S_MULT  = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_FIN   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [CNT_DW-1:0] cnt_ff, cnt_in;
   logic [X_W-1:0]    x0_ff, x0_in, x1_ff, x1_in, xq_ff, xq_in;
   logic [Y_W-1:0]    y0_ff, y0_in, y1_ff, y1_in;
   logic              flag_ff, flag_in, direct_ff, direct_in, one_ff, one_in;
   logic [X_W-1:0]    mq_ff, mq_in, dx_ff, dx_in;
   logic [Y_W-1:0]    my_ff, my_in;
   logic              neg_ff, neg_in, degen_ff, degen_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [X_W-1:0]    rem_ff, rem_in;
   logic [QB-1:0]     quo_ff, quo_in;
   logic [Y_W-1:0]    res_ff, res_in;
   logic              oor_ff, oor_in;

   logic [X_W:0]      trial;
   logic [QB-1:0]     quo_c;
   logic [RES_W-1:0]  sum;

   assign trial = {rem_ff, quo_ff[QB-1]} - {1'b0, dx_ff};
   assign quo_c = (quo_ff > QUO_CAP) ? QUO_CAP : quo_ff;

   always_comb begin
      if (degen_ff) begin
         sum = RES_W'(y1_ff);
      end else if (neg_ff) begin
         sum = RES_W'(y0_ff) - RES_W'(quo_c);
      end else begin
         sum = RES_W'(y0_ff) + RES_W'(quo_c);
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      x0_in     = x0_ff;
      x1_in     = x1_ff;
      xq_in     = xq_ff;
      y0_in     = y0_ff;
      y1_in     = y1_ff;
      flag_in   = flag_ff;
      direct_in = direct_ff;
      one_in    = one_ff;
      mq_in     = mq_ff;
      my_in     = my_ff;
      dx_in     = dx_ff;
      neg_in    = neg_ff;
      degen_in  = degen_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      res_in    = res_ff;
      oor_in    = oor_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               x0_in     = tok_i.x0;
               x1_in     = tok_i.x1;
               xq_in     = tok_i.xq;
               y0_in     = tok_i.y0;
               y1_in     = tok_i.y1;
               flag_in   = tok_i.flag;
               direct_in = tok_i.direct;
               one_in    = tok_i.direct_one;
               state_in  = S_PREP;
            end
         end
         S_PREP: begin
            mq_in    = (xq_ff >= x0_ff) ? (xq_ff - x0_ff) : (x0_ff - xq_ff);
            my_in    = (y1_ff >= y0_ff) ? (y1_ff - y0_ff) : (y0_ff - y1_ff);
            neg_in   = (xq_ff < x0_ff) != (y1_ff < y0_ff);
            dx_in    = x1_ff - x0_ff;
            degen_in = (x1_ff <= x0_ff);
            state_in = (direct_ff || (x1_ff <= x0_ff)) ? S_FIN : S_MULT;
         end
         S_MULT: begin
            prod_in  = mq_ff * my_ff;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            // quotient too large for QB bits: it saturates anyway
            if ({1'b0, prod_ff} >= {dx_ff, {QB{1'b0}}}) begin
               quo_in   = QUO_CAP;
               state_in = S_FIN;
            end else begin
               rem_in   = X_W'(prod_ff >> QB);
               quo_in   = prod_ff[QB-1:0];
               cnt_in   = CNT_DW'(QB);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!trial[X_W]) begin
               rem_in = trial[X_W-1:0];
               quo_in = {quo_ff[QB-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[X_W-2:0], quo_ff[QB-1]};
               quo_in = {quo_ff[QB-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_ONE;
            if (cnt_ff == CNT_ONE) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (direct_ff) begin
               res_in = one_ff ? Y_ONE : '0;
               oor_in = 1'b0;
            end else if (sum[RES_W-1]) begin
               res_in = '0;
               oor_in = 1'b1;
            end else if (sum > RES_W'(Y_ONE)) begin
               res_in = Y_ONE;
               oor_in = 1'b1;
            end else begin
               res_in = Y_W'(sum);
               oor_in = flag_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      x0_ff     <= x0_in;
      x1_ff     <= x1_in;
      xq_ff     <= xq_in;
      y0_ff     <= y0_in;
      y1_ff     <= y1_in;
      flag_ff   <= flag_in;
      direct_ff <= direct_in;
      one_ff    <= one_in;
      mq_ff     <= mq_in;
      my_ff     <= my_in;
      dx_ff     <= dx_in;
      neg_ff    <= neg_in;
      degen_ff  <= degen_in;
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      res_ff    <= res_in;
      oor_ff    <= oor_in;
   end

   assign stat_o.idle        = (state_ff == S_IDLE);
   assign stat_o.done        = (state_ff == S_DONE);
   assign res_o.y_result     = res_ff;
   assign res_o.out_of_range = oor_ff;

endmodule

`default_nettype wire

// ===== rtl/core/piecewise_linear_interpolator.sv =====
// Piecewise linear interpolator. A load (func 0) writes breakpoint entry_index and
// gives no result; a query (func 1) gives one result. A query token walks a chain of MAX_POINTS
// cells, one cell per clock, picking the segment that ends at the first breakpoint at or above x
// (the first or last segment when x lies outside the breakpoints), then one multiply and a
// restoring divide of Y_FRAC_BITS+2 steps finish it. Infinite and zero queries and segments of
// zero or negative width skip the divide; a quotient too large to fit skips it too. One query is
// in flight at a time; the next request is taken the cycle after the previous result enters the
// output register, and loads are taken one per cycle while no query is in flight. Entries hold
// nothing until loaded.
// depends on pli_pkg, pli_cell, pli_arith
`default_nettype none

module piecewise_linear_interpolator #(
   parameter int MAX_POINTS = pli_pkg::DEF_MAX_POINTS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire pli_pkg::req_type          req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output pli_pkg::rsp_type               rsp_data,
   input  wire logic                      csr_we,
   input  wire logic [pli_pkg::CFG_W-1:0] csr_wdata
);
   import pli_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   logic [CFG_W-1:0] point_count_ff, point_count_in;
   logic [CNT_W-1:0] n_eff;
   logic             busy_ff, busy_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             req_xfer;
   logic             query_go;
   load_type         load_bus;
   token_type        tok [0:MAX_POINTS];
   logic [MAX_POINTS-1:0] active_vec;
   arith_stat_type   arith_stat;
   rsp_type          arith_res;
   logic             take;

   assign req_ready = !busy_ff;
   assign req_xfer  = req_valid && req_ready;
   assign query_go  = req_xfer && (req_data.func == FUNC_QUERY);

   assign point_count_in = csr_we ? csr_wdata : point_count_ff;

   always_comb begin
      if (point_count_ff < 7'd2) begin
         n_eff = CNT_W'(2);
      end else if (32'(point_count_ff) > 32'(MAX_POINTS)) begin
         n_eff = CNT_W'(MAX_POINTS);
      end else begin
         n_eff = CNT_W'(point_count_ff);
      end
   end

   assign load_bus.en   = req_xfer && (req_data.func == FUNC_LOAD);
   assign load_bus.slot = req_data.entry_index;
   assign load_bus.x    = req_data.x_value;
   assign load_bus.y    = req_data.y_value;

   always_comb begin
      tok[0]            = '0;
      tok[0].active     = query_go;
      tok[0].xq         = req_data.x_value;
      tok[0].direct     = req_data.is_infinite || (req_data.x_value == '0);
      tok[0].direct_one = req_data.is_infinite;
   end

   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      pli_cell #(
         .MAX_POINTS (MAX_POINTS),
         .CELL_INDEX (i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .load_i (load_bus),
         .n_eff  (n_eff),
         .tok_i  (tok[i]),
         .tok_o  (tok[i+1])
      );
      assign active_vec[i] = tok[i+1].active;
   end

   pli_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .start  (tok[MAX_POINTS].active),
      .tok_i  (tok[MAX_POINTS]),
      .take   (take),
      .stat_o (arith_stat),
      .res_o  (arith_res)
   );

   // output register frees the arithmetic unit while the result waits
   assign take         = arith_stat.done && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = take || (rsp_valid_ff && !rsp_ready);
   assign rsp_data_in  = take ? arith_res : rsp_data_ff;

   always_comb begin
      busy_in = busy_ff;
      if (query_go) begin
         busy_in = 1'b1;
      end else if (take) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= POINT_COUNT_RESET;
         busy_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         point_count_ff <= point_count_in;
         busy_ff        <= busy_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // one query token in the chain at most
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(active_vec) <= 1)
      else $error("more than one query token in the cell chain");

   // token leaving the chain always finds the arithmetic unit free
   a_arith_free: assert property (@(posedge clock) disable iff (reset)
      tok[MAX_POINTS].active |-> arith_stat.idle)
      else $error("query token reached a busy arithmetic unit");

   // when ready again, nothing of the last query is still in flight
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (active_vec == '0) && arith_stat.idle)
      else $error("request port ready while a query is still in flight");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.y_result <= Y_ONE))
      else $error("result above one");

endmodule

`default_nettype wire

// ===== verif/tb_piecewise_linear_interpolator.sv =====
// testbench for piecewise_linear_interpolator: loads breakpoint tables, runs interpolation
// queries under random idling and checks every result against an in-bench predictor
// depends on pli_pkg and the piecewise_linear_interpolator rtl
`timescale 1ns / 100ps

module tb_piecewise_linear_interpolator;
   import pli_pkg::*;

   localparam int     RANDOM_ITEMS  = 1400;
   localparam int     SETTLE_CYCLES = 100;
   localparam int     LONG_HOLD     = 800;
   localparam longint ONE_WIDE      = longint'(Y_ONE);

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

   // breakpoint tables, point count and pending query results
   class interp_scoreboard;
      logic [X_W-1:0]   x_tab [DEF_MAX_POINTS];
      logic [Y_W-1:0]   y_tab [DEF_MAX_POINTS];
      logic [CFG_W-1:0] point_count;
      rsp_type          pending_results [$];
      int               errors;

      function new();
         point_count = POINT_COUNT_RESET;
         errors = 0;
         foreach (x_tab[i]) begin
            x_tab[i] = '0;
            y_tab[i] = '0;
         end
      endfunction

      function void set_point_count(logic [CFG_W-1:0] value);
         point_count = value;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function rsp_type interpolate(req_type q);
         rsp_type r;
         int unsigned n, k;
         logic flag, neg;
         longint x0, x1, y0, y1, dx, dq, dy, res;
         longint unsigned mq, my, quo;
         r.y_result = '0;
         r.out_of_range = 1'b0;
         if (q.is_infinite) begin
            r.y_result = Y_ONE;
            return r;
         end
         if (q.x_value == '0) return r;
         n = point_count;
         if (n < 2) n = 2;
         if (n > DEF_MAX_POINTS) n = DEF_MAX_POINTS;
         k = 0;
         while (k < n && x_tab[k] < q.x_value) k++;
         flag = 1'b0;
         if (k == 0) begin
            k = 1;
            flag = (q.x_value < x_tab[0]);
         end else if (k >= n) begin
            k = n - 1;
            flag = 1'b1;
         end
         x0 = {32'd0, x_tab[k-1]};
         x1 = {32'd0, x_tab[k]};
         y0 = {47'd0, y_tab[k-1]};
         y1 = {47'd0, y_tab[k]};
         dx = x1 - x0;
         if (dx <= 0) begin
            res = y1;
         end else begin
            dq = {32'd0, q.x_value};
            dq = dq - x0;
            dy = y1 - y0;
            neg = (dq < 0) != (dy < 0);
            mq = (dq < 0) ? -dq : dq;
            my = (dy < 0) ? -dy : dy;
            quo = (mq * my) / longint'(dx);
            if (quo > 2 * ONE_WIDE) quo = 2 * ONE_WIDE;
            res = neg ? y0 - longint'(quo) : y0 + longint'(quo);
         end
         // saturate to 0..1.0
         if (res < 0) begin
            res = 0;
            flag = 1'b1;
         end else if (res > ONE_WIDE) begin
            res = ONE_WIDE;
            flag = 1'b1;
         end
         r.y_result = res[Y_W-1:0];
         r.out_of_range = flag;
         return r;
      endfunction

      function void note_request(req_type r);
         if (r.func == FUNC_LOAD) begin
            x_tab[r.entry_index] = r.x_value;
            y_tab[r.entry_index] = r.y_value;
         end else begin
            pending_results.push_back(interpolate(r));
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            $error("result y_result=%0d out_of_range=%0d with no query pending",
                   got.y_result, got.out_of_range);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (got.y_result !== want.y_result) begin
            $error("y_result: expected %0d, got %0d", want.y_result, got.y_result);
            errors++;
         end
         if (got.out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %0d, got %0d", want.out_of_range, got.out_of_range);
            errors++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_data;
   logic             csr_we;
   logic [CFG_W-1:0] csr_wdata;

   interp_scoreboard sb = new();

   int             send_idle_pct = 0;
   int             stall_pct = 0;
   int             hold_cycles = 0;
   int             items_sent = 0;
   logic [X_W-1:0] stim_x [DEF_MAX_POINTS];
   logic [CFG_W-1:0] count_extremes [6] = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd65, 7'd127};

   piecewise_linear_interpolator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("simulation failed");
      $finish;
   end

   // receiver: random stalls, or a long hold-off when one is requested
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   function automatic req_type make_req(logic func, logic [IDX_W-1:0] slot,
                                        logic [X_W-1:0] x, logic [Y_W-1:0] y, logic inf);
      req_type r;
      r.func = func;
      r.entry_index = slot;
      r.x_value = x;
      r.y_value = y;
      r.is_infinite = inf;
      return r;
   endfunction

   function automatic logic [Y_W-1:0] random_y();
      case ($urandom_range(7))
         0: return '0;
         1: return Y_ONE;
         default: return Y_W'($urandom_range(0, 65536));
      endcase
   endfunction

   function void set_idling(idle_mode_e mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 60;
            stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            stall_pct = 60;
         end
         default: begin
            send_idle_pct = 16;
            stall_pct = 16;
         end
      endcase
   endfunction

   // offer one item after a random gap and hold it until the transfer
   task automatic issue(req_type item);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
      items_sent++;
   endtask

   task automatic pause_and_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_point_count(logic [CFG_W-1:0] value);
      pause_and_drain();
      // a load may still be settling after the last result
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_point_count(value);
   endtask

   // fills slots 0..n-1, mostly ascending, sometimes with repeats or unsorted
   task automatic load_table(int unsigned n);
      int unsigned    step_max, shape, i;
      longint unsigned x;
      shape = $urandom_range(9);
      step_max = 32'd1 << $urandom_range(2, 26);
      x = ($urandom_range(3) == 0) ? 64'd0 : 64'($urandom_range(1, step_max));
      for (i = 0; i < n; i++) begin
         if (i > 0) begin
            if (shape == 0) x = 64'($urandom);
            else if (!(shape == 1 && $urandom_range(2) == 0))
               x += 64'($urandom_range(1, step_max));
         end
         if (x > 64'hFFFF_FFFF) x = 64'hFFFF_FFFF;
         if (i == n - 1 && $urandom_range(4) == 0) x = 64'hFFFF_FFFF;
         stim_x[i] = x[31:0];
         issue(make_req(FUNC_LOAD, IDX_W'(i), x[31:0], random_y(), $urandom_range(3) == 0));
      end
   endtask

   function automatic req_type random_query(int unsigned n);
      req_type     q;
      int unsigned k;
      logic [X_W-1:0] lo, hi;
      q = make_req(FUNC_QUERY, IDX_W'($urandom_range(63)), $urandom,
                   Y_W'($urandom_range(0, 65536)), 1'b0);
      lo = stim_x[0];
      hi = stim_x[n-1];
      case ($urandom_range(9))
         0: q.x_value = stim_x[$urandom_range(n - 1)];
         1: begin
            if (lo > 1) q.x_value = $urandom_range(1, lo - 1);
            else q.x_value = 32'd1;
         end
         2: begin
            if (hi != '1) q.x_value = $urandom_range(hi + 1, 32'hFFFF_FFFF);
            else q.x_value = hi;
         end
         3: q.x_value = '0;
         4: q.is_infinite = 1'b1;
         5: ;
         default: begin
            k = $urandom_range(1, n - 1);
            q.x_value = $urandom_range(stim_x[k-1], stim_x[k]);
         end
      endcase
      return q;
   endfunction

   initial begin
      int unsigned      n, nq, j, slot, seq;
      logic [CFG_W-1:0] count;
      logic             rewrite;
      req_type          noise;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // two points in use after reset
      set_idling(IDLE_NONE);
      issue(make_req(FUNC_LOAD, 6'd0, 32'h0001_0000, 17'h0_4000, 1'b0));
      issue(make_req(FUNC_LOAD, 6'd1, 32'h0003_0000, 17'h0_C000, 1'b0));
      issue(make_req(FUNC_QUERY, 6'd0, 32'h0000_0000, 17'h1_FFFF, 1'b1));
      issue(make_req(FUNC_QUERY, 6'd63, 32'h0000_0000, 17'h0, 1'b0));
      issue(make_req(FUNC_QUERY, 6'd0, 32'h0001_0000, 17'h0, 1'b0));
      issue(make_req(FUNC_QUERY, 6'd0, 32'h0002_0000, 17'h0, 1'b0));
      issue(make_req(FUNC_QUERY, 6'd0, 32'h0003_0000, 17'h0, 1'b0));
      issue(make_req(FUNC_QUERY, 6'd0, 32'h0000_8000, 17'h0, 1'b0));
      issue(make_req(FUNC_QUERY, 6'd0, 32'h0000_0001, 17'h0, 1'b0));
      issue(make_req(FUNC_QUERY, 6'd0, 32'hFFFF_FFFF, 17'h0, 1'b0));
      issue(make_req(FUNC_QUERY, 6'd0, 32'h0004_0000, 17'h0, 1'b0));
      // zero-width segment, with the infinity bit set on the load
      issue(make_req(FUNC_LOAD, 6'd1, 32'h0001_0000, Y_ONE, 1'b1));
      issue(make_req(FUNC_QUERY, 6'd0, 32'h0000_8000, 17'h0, 1'b0));
      issue(make_req(FUNC_QUERY, 6'd0, 32'h0001_0000, 17'h0, 1'b0));
      // full x range, falling y
      issue(make_req(FUNC_LOAD, 6'd0, 32'h0000_0000, Y_ONE, 1'b0));
      issue(make_req(FUNC_LOAD, 6'd1, 32'hFFFF_FFFF, 17'h0, 1'b0));
      issue(make_req(FUNC_QUERY, 6'd0, 32'h8000_0000, 17'h0, 1'b0));
      issue(make_req(FUNC_QUERY, 6'd0, 32'hFFFF_FFFF, 17'h0, 1'b0));
      issue(make_req(FUNC_QUERY, 6'd0, 32'h5555_5555, 17'h0, 1'b0));
      issue(make_req(FUNC_LOAD, 6'd63, 32'hFFFF_FFFF, Y_ONE, 1'b0));
      // steep segment: extrapolation below the first point clamps at zero
      issue(make_req(FUNC_LOAD, 6'd0, 32'h8000_0000, 17'h0, 1'b0));
      issue(make_req(FUNC_LOAD, 6'd1, 32'h8001_0000, Y_ONE, 1'b0));
      issue(make_req(FUNC_QUERY, 6'd0, 32'h0000_0010, 17'h0, 1'b0));
      issue(make_req(FUNC_QUERY, 6'd0, 32'h8000_8000, 17'h0, 1'b0));

      items_sent = 0;
      seq = 0;
      count = POINT_COUNT_RESET;
      while (items_sent < RANDOM_ITEMS) begin
         set_idling(idle_mode_e'(seq % 4));
         rewrite = 1'b1;
         if (seq < 6) begin
            count = count_extremes[seq];
         end else if ($urandom_range(1) == 0) begin
            case ($urandom_range(5))
               0: count = CFG_W'($urandom_range(127));
               1: count = CFG_W'($urandom_range(13, 64));
               default: count = CFG_W'($urandom_range(2, 12));
            endcase
         end else begin
            rewrite = 1'b0;
         end
         if (rewrite) write_point_count(count);
         n = (count < 2) ? 2 : (count > DEF_MAX_POINTS) ? DEF_MAX_POINTS : count;
         load_table(n);
         // long receiver hold-off while the sender keeps offering queries
         if (seq == 2) hold_cycles = LONG_HOLD;
         nq = $urandom_range(4, 24);
         for (j = 0; j < nq; j++) begin
            if (seq == 3 && j == nq / 2) pause_and_drain();
            if ($urandom_range(7) == 0) begin
               slot = $urandom_range(63);
               noise = make_req(FUNC_LOAD, IDX_W'(slot), $urandom, random_y(),
                                $urandom_range(1) == 0);
               if (slot < n) stim_x[slot] = noise.x_value;
               issue(noise);
            end else begin
               issue(random_query(n));
            end
         end
         seq++;
      end

      pause_and_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
